FILE: rtl/sorted_block_search_insert_assert.svh
// Assertion macros shared by the checker of the sorted block search and insert unit.
// No dependencies beyond the including module's clock and reset.
`ifndef SORTED_BLOCK_SEARCH_INSERT_ASSERT_SVH
`define SORTED_BLOCK_SEARCH_INSERT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SBSI_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);
// Implication checked in the cycle after the condition.
`define SBSI_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);
`endif

FILE: rtl/sbsi_pkg.sv
// Shared types and constants of the sorted block search and insert unit.
// No dependencies.
package sbsi_pkg;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int SLOTS_DEF       = 64;
    localparam int CHILD_WIDTH_DEF = 32;
    localparam int CFG_IDX_WIDTH   = 2;

    localparam logic [2:0] CMD_SEARCH = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_NEXT   = 3'd2;
    localparam logic [2:0] CMD_LAST   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_END       = 3'd3;
    localparam logic [2:0] ST_NOT_POS   = 3'd4;

    localparam logic [1:0] CFG_INTERIOR  = 2'd0;
    localparam logic [1:0] CFG_CAPACITY  = 2'd1;
    localparam logic [1:0] CFG_END_CHILD = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key;
        logic [31:0] child_in;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_key;
        logic [6:0]  position;
        logic [31:0] child_out;
        logic [6:0]  entry_count;
    } out_word_t;
endpackage

FILE: rtl/sbsi_store.sv
// Key and child memory of the sorted block: one write port and one registered read port.
// Depends on nothing beyond its parameters.
module sbsi_store #(
    parameter int KEY_WIDTH   = 32,
    parameter int CHILD_WIDTH = 32,
    parameter int SLOTS       = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  logic [KEY_WIDTH-1:0]     wr_key,
    input  logic [CHILD_WIDTH-1:0]   wr_child,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic [KEY_WIDTH-1:0]     rd_key,
    output logic [CHILD_WIDTH-1:0]   rd_child
);
    logic [KEY_WIDTH-1:0]   key_mem [SLOTS];
    logic [CHILD_WIDTH-1:0] child_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            child_mem[wr_addr] <= wr_child;
        end
        rd_key   <= key_mem[rd_addr];
        rd_child <= child_mem[rd_addr];
    end
endmodule

FILE: rtl/sorted_block_search_insert.sv
// Sorted block search and insert unit: top level with sequencer and shared compare unit.
// Depends on sbsi_pkg and sbsi_store.
//
// Usage: the s_ channel takes one command word (search, insert at cursor, get next,
// get last, clear); the m_ channel returns one result word per command. The
// cfg channel writes node_interior (0), capacity (1) and end_child_addr (2); the user
// is to write them only while the block is idle, which the block itself does not
// enforce. One command is worked at a time; s_ready is low meanwhile. Search
// alternates a probe state, which reads the memory, and a compare state, through a
// single memory read port and comparator. Insert moves entries up one slot each,
// reading then writing through the same port, and then writes the new entry. A
// search on an empty table, next and last at end of set, clear and unused codes
// answer straight from the idle state. The result sits in an output register until
// m_ready; the next command is taken only after it leaves. Synchronous reset empties
// the table, clears the cursor and loads the register defaults; the memories are not
// cleared, since entries at or above the count are never read.
module sorted_block_search_insert
    import sbsi_pkg::in_word_t, sbsi_pkg::out_word_t;
#(
    parameter int KEY_WIDTH   = sbsi_pkg::KEY_WIDTH_DEF,
    parameter int SLOTS       = sbsi_pkg::SLOTS_DEF,
    parameter int CHILD_WIDTH = sbsi_pkg::CHILD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sbsi_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import sbsi_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_CMP, S_SHIFT_RD, S_SHIFT_WR, S_FETCH, S_DONE
    } state_t;

    state_t state_reg;
    logic                 interior_reg;
    logic [6:0]           capacity_reg;
    logic [31:0]          end_child_reg;
    logic [CW-1:0]        count_reg, cursor_reg;
    logic                 cursor_valid_reg;
    logic [CW-1:0]        lo_reg, hi_reg, mid_reg, idx_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CHILD_WIDTH-1:0] child_reg;
    logic [2:0]           cmd_reg;
    out_word_t            out_reg;
    logic                 out_valid_reg;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [KEY_WIDTH-1:0]   wr_key, rd_key;
    logic [CHILD_WIDTH-1:0] wr_child, rd_child;
    logic [CW-1:0]          usable, ins_pos;

    sbsi_store #(.KEY_WIDTH(KEY_WIDTH), .CHILD_WIDTH(CHILD_WIDTH), .SLOTS(SLOTS)) u_store (
        .aclk, .wr_en, .wr_addr, .wr_key, .wr_child, .rd_addr, .rd_key, .rd_child
    );

    assign s_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        if (32'(capacity_reg) > 32'(SLOTS)) begin
            usable = CW'(SLOTS);
        end else begin
            usable = CW'(capacity_reg);
        end
        ins_pos = (cursor_reg > count_reg) ? count_reg : cursor_reg;
    end

    // Memory port use: shifting reads idx-1 and writes idx; other states read the probe.
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = idx_reg[AW-1:0];
        wr_key   = rd_key;
        wr_child = rd_child;
        rd_addr  = mid_reg[AW-1:0];
        if (state_reg == S_SHIFT_RD) begin
            rd_addr = AW'(idx_reg - 1'b1);
        end else if (state_reg == S_SHIFT_WR) begin
            wr_en = 1'b1;
        end else if (state_reg == S_DONE && cmd_reg == CMD_INSERT) begin
            wr_en    = 1'b1;
            wr_key   = key_reg;
            wr_child = child_reg;
        end
    end

    function automatic out_word_t mk(input logic [2:0] st, input logic [31:0] fk,
                                     input logic [CW-1:0] pos, input logic [31:0] ch,
                                     input logic [CW-1:0] cnt);
        out_word_t o;
        o.status      = st;
        o.found_key   = fk;
        o.position    = 7'(pos);
        o.child_out   = ch;
        o.entry_count = 7'(cnt);
        return o;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            interior_reg     <= 1'b0;
            capacity_reg     <= 7'd64;
            end_child_reg    <= '0;
            count_reg        <= '0;
            cursor_reg       <= '0;
            cursor_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_INTERIOR:  interior_reg  <= cfg_data[0];
                    CFG_CAPACITY:  capacity_reg  <= cfg_data[6:0];
                    CFG_END_CHILD: end_child_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg   <= s_data.command;
                        key_reg   <= KEY_WIDTH'(s_data.key);
                        child_reg <= CHILD_WIDTH'(s_data.child_in);
                        case (s_data.command)
                            CMD_SEARCH: begin
                                lo_reg  <= '0;
                                hi_reg  <= count_reg - 1'b1;
                                mid_reg <= (count_reg - 1'b1) >> 1;
                                if (count_reg == '0) begin
                                    cursor_reg       <= '0;
                                    cursor_valid_reg <= 1'b1;
                                    out_reg <= mk(ST_NOT_FOUND, '0, '0,
                                        interior_reg ? end_child_reg : '0, count_reg);
                                    out_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= S_PROBE;
                                end
                            end
                            CMD_INSERT: begin
                                if (count_reg >= usable) begin
                                    out_reg <= mk(ST_FULL, '0,
                                        cursor_valid_reg ? cursor_reg : '0, '0, count_reg);
                                    out_valid_reg <= 1'b1;
                                end else if (!cursor_valid_reg) begin
                                    out_reg <= mk(ST_NOT_POS, '0, '0, '0, count_reg);
                                    out_valid_reg <= 1'b1;
                                end else begin
                                    idx_reg   <= count_reg;
                                    mid_reg   <= ins_pos;
                                    state_reg <= (count_reg > ins_pos) ? S_SHIFT_RD : S_DONE;
                                end
                            end
                            CMD_NEXT: begin
                                mid_reg <= cursor_valid_reg ? cursor_reg + 1'b1 : '0;
                                if ((cursor_valid_reg ? 32'(cursor_reg) + 1 : 0)
                                        >= 32'(count_reg)) begin
                                    out_reg <= mk(ST_END, '0,
                                        cursor_valid_reg ? cursor_reg : '0, '0, count_reg);
                                    out_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= S_FETCH;
                                end
                            end
                            CMD_LAST: begin
                                mid_reg <= count_reg - 1'b1;
                                if (count_reg == '0) begin
                                    out_reg <= mk(ST_END, '0,
                                        cursor_valid_reg ? cursor_reg : '0, '0, count_reg);
                                    out_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= S_FETCH;
                                end
                            end
                            CMD_CLEAR: begin
                                count_reg        <= '0;
                                cursor_reg       <= '0;
                                cursor_valid_reg <= 1'b0;
                                out_reg <= mk(ST_OK, '0, '0, '0, '0);
                                out_valid_reg <= 1'b1;
                            end
                            default: begin
                                out_reg <= mk(ST_OK, '0,
                                    cursor_valid_reg ? cursor_reg : '0, '0, count_reg);
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PROBE: state_reg <= S_CMP;
                S_CMP: begin
                    // One probe of the binary search on the registered memory word.
                    if (key_reg == rd_key || (key_reg < rd_key && (mid_reg == lo_reg ||
                            lo_reg == hi_reg)) || (key_reg > rd_key &&
                            (mid_reg == hi_reg || lo_reg == hi_reg))) begin
                        if (key_reg > rd_key) begin
                            mid_reg <= mid_reg + 1'b1;
                        end
                        state_reg <= S_FETCH;
                    end else if (key_reg < rd_key) begin
                        hi_reg    <= mid_reg - 1'b1;
                        mid_reg   <= (lo_reg + mid_reg - 1'b1) >> 1;
                        state_reg <= S_PROBE;
                    end else begin
                        lo_reg    <= mid_reg + 1'b1;
                        mid_reg   <= (mid_reg + 1'b1 + hi_reg) >> 1;
                        state_reg <= S_PROBE;
                    end
                    idx_reg <= {{(CW-1){1'b0}}, key_reg == rd_key};
                end
                S_SHIFT_RD: state_reg <= S_SHIFT_WR;
                S_SHIFT_WR: begin
                    idx_reg   <= idx_reg - 1'b1;
                    state_reg <= (idx_reg - 1'b1 > mid_reg) ? S_SHIFT_RD : S_DONE;
                end
                S_FETCH: state_reg <= S_DONE;
                S_DONE: begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b1;
                    case (cmd_reg)
                        CMD_SEARCH: begin
                            cursor_reg       <= mid_reg;
                            cursor_valid_reg <= 1'b1;
                            out_reg <= mk(idx_reg[0] ? ST_OK : ST_NOT_FOUND,
                                idx_reg[0] ? 32'(key_reg) : '0, mid_reg,
                                !interior_reg ? '0 : (mid_reg >= count_reg) ?
                                end_child_reg : 32'(rd_child), count_reg);
                        end
                        CMD_INSERT: begin
                            count_reg  <= count_reg + 1'b1;
                            cursor_reg <= mid_reg + 1'b1;
                            out_reg <= mk(ST_OK, 32'(key_reg), mid_reg + 1'b1, '0,
                                count_reg + 1'b1);
                        end
                        default: begin
                            cursor_reg       <= mid_reg;
                            cursor_valid_reg <= 1'b1;
                            out_reg <= mk(ST_OK, 32'(rd_key), mid_reg, '0, count_reg);
                        end
                    endcase
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/sbsi_checker.sv
// Port-level checker of the sorted block search and insert unit, with its bind.
// Depends on sbsi_pkg and sorted_block_search_insert_assert.svh.
`include "sorted_block_search_insert_assert.svh"
module sbsi_checker
    import sbsi_pkg::out_word_t;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);
    import sbsi_pkg::*;

    `SBSI_ASSERT_IMPL(a_one_at_a_time, aclk, aresetn, m_valid, !s_ready,
        "input taken while a result word waits")
    `SBSI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready,
        "ready stayed high after a word was accepted")
    `SBSI_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result word changed while stalled")
    `SBSI_ASSERT_IMPL(a_count_bound, aclk, aresetn, m_valid,
        m_data.entry_count <= 7'd64 && m_data.status <= ST_NOT_POS,
        "result word out of range")
endmodule

bind sorted_block_search_insert sbsi_checker u_sbsi_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);

FILE: bench/tb_sorted_block_search_insert.sv
// Self-checking bench for the sorted block search and insert unit.
// Depends on sbsi_pkg and sorted_block_search_insert; a scoreboard class predicts results.
`timescale 1ns / 1ps

module tb_sorted_block_search_insert;
    import sbsi_pkg::*;

    localparam int NSLOT = 64;
    localparam int STALL_LIMIT = 20000;

    class block_scoreboard;
        bit          interior;
        logic [6:0]  capacity;
        logic [31:0] end_child;
        logic [31:0] keys [NSLOT];
        logic [31:0] childs [NSLOT];
        int          count;
        int          cursor;
        bit          cursor_set;
        out_word_t   pending [$];
        int          errors;

        function void init();
            interior = 0;
            capacity = 7'd64;
            end_child = '0;
            count = 0;
            cursor = 0;
            cursor_set = 0;
            errors = 0;
            pending.delete();
            foreach (keys[i]) begin
                keys[i] = '0;
                childs[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_INTERIOR:  interior = val[0];
                CFG_CAPACITY:  capacity = val[6:0];
                CFG_END_CHILD: end_child = val;
                default: ;
            endcase
        endfunction

        function out_word_t word(logic [2:0] st, logic [31:0] fk, int pos, logic [31:0] ch);
            out_word_t r;
            r.status = st;
            r.found_key = fk;
            r.position = pos[6:0];
            r.child_out = ch;
            r.entry_count = count[6:0];
            return r;
        endfunction

        function void note_input(in_word_t w);
            int lo, hi, mid, usable, pos;
            bit hit;
            logic [31:0] ch;
            lo = 0;
            mid = 0;
            hit = 0;
            ch = '0;
            case (w.command)
                CMD_SEARCH: begin
                    if (count != 0) begin
                        hi = count - 1;
                        forever begin
                            mid = (lo + hi) >> 1;
                            if (w.key == keys[mid]) begin
                                hit = 1;
                                break;
                            end
                            if (w.key < keys[mid]) begin
                                if (mid == lo || lo == hi) break;
                                hi = mid - 1;
                            end else begin
                                if (mid == hi || lo == hi) begin
                                    mid++;
                                    break;
                                end
                                lo = mid + 1;
                            end
                        end
                    end
                    cursor = mid;
                    cursor_set = 1;
                    if (interior) ch = (mid >= count) ? end_child : childs[mid];
                    pending.push_back(word(hit ? ST_OK : ST_NOT_FOUND,
                                           hit ? w.key : '0, mid, ch));
                end
                CMD_INSERT: begin
                    usable = (capacity > NSLOT) ? NSLOT : capacity;
                    if (count >= usable)
                        pending.push_back(word(ST_FULL, '0, cursor_set ? cursor : 0, '0));
                    else if (!cursor_set)
                        pending.push_back(word(ST_NOT_POS, '0, 0, '0));
                    else begin
                        pos = (cursor > count) ? count : cursor;
                        for (int i = count; i > pos; i--) begin
                            keys[i] = keys[i-1];
                            childs[i] = childs[i-1];
                        end
                        keys[pos] = w.key;
                        childs[pos] = w.child_in;
                        count++;
                        cursor = pos + 1;
                        pending.push_back(word(ST_OK, w.key, cursor, '0));
                    end
                end
                CMD_NEXT: begin
                    pos = cursor_set ? cursor + 1 : 0;
                    if (pos >= count)
                        pending.push_back(word(ST_END, '0, cursor_set ? cursor : 0, '0));
                    else begin
                        cursor = pos;
                        cursor_set = 1;
                        pending.push_back(word(ST_OK, keys[pos], pos, '0));
                    end
                end
                CMD_LAST: begin
                    if (count == 0)
                        pending.push_back(word(ST_END, '0, cursor_set ? cursor : 0, '0));
                    else begin
                        cursor = count - 1;
                        cursor_set = 1;
                        pending.push_back(word(ST_OK, keys[cursor], cursor, '0));
                    end
                end
                CMD_CLEAR: begin
                    count = 0;
                    cursor = 0;
                    cursor_set = 0;
                    pending.push_back(word(ST_OK, '0, 0, '0));
                end
                default: pending.push_back(word(ST_OK, '0, cursor_set ? cursor : 0, '0));
            endcase
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result word %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.found_key !== exp.found_key ||
                got.position !== exp.position || got.child_out !== exp.child_out ||
                got.entry_count !== exp.entry_count) begin
                errors++;
                if (errors <= 10)
                    $display({"Result mismatch: expected st=%0d key=%h pos=%0d ch=%h cnt=%0d,",
                              " got st=%0d key=%h pos=%0d ch=%h cnt=%0d"},
                             exp.status, exp.found_key, exp.position, exp.child_out,
                             exp.entry_count, got.status, got.found_key, got.position,
                             got.child_out, got.entry_count);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_word_t   m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    block_scoreboard board;
    bit  calm = 0;          // no idling on either side while set
    bit  hold_sink = 0;     // long receiver hold-off
    int  quiet_cycles = 0;

    sorted_block_search_insert dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // Receiver: random stalls, none in calm stretches, none while held off.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if (hold_sink) m_ready <= 1'b0;
        else m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Valid stays up between back-to-back words; it drops only for idle cycles or drain.
    task automatic send_word(logic [2:0] cmd, logic [31:0] k, logic [31:0] ch);
        in_word_t w;
        w.command = cmd;
        w.key = k;
        w.child_in = ch;
        while (!calm && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_input(w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Keys near a small pool so that hits and duplicates are common.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom();
            1: return ($urandom_range(1) ? 32'hFFFF_FFC0 : 32'h0) | 32'($urandom_range(63));
            default: return $urandom_range(40) * 32'h0404_0401;
        endcase
    endfunction

    task automatic random_phase(int n);
        int r;
        logic [2:0] cmd;
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            k = pick_key();
            if (r < 30) cmd = CMD_SEARCH;
            else if (r < 65) cmd = CMD_INSERT;
            else if (r < 78) cmd = CMD_NEXT;
            else if (r < 86) cmd = CMD_LAST;
            else if (r < 90) cmd = CMD_CLEAR;
            else if (r < 93) cmd = 3'($urandom_range(5, 7));
            else begin
                // Search then insert of the same key keeps the table sorted.
                send_word(CMD_SEARCH, k, $urandom());
                cmd = CMD_INSERT;
            end
            send_word(cmd, k, $urandom());
        end
    endtask

    initial begin
        board = new();
        board.init();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, unset cursor, extremes of keys.
        calm = 1;
        send_word(CMD_INSERT, 32'h1234, 32'h1);
        send_word(CMD_NEXT, '0, '0);
        send_word(CMD_LAST, '0, '0);
        send_word(CMD_SEARCH, 32'hFFFF_FFFF, '0);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_SEARCH, '0, '0);
        send_word(CMD_INSERT, '0, '0);
        send_word(CMD_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
        send_word(CMD_INSERT, 32'h8000_0000, 32'h5A5A_A5A5);
        send_word(CMD_SEARCH, 32'h8000_0000, '0);
        send_word(CMD_SEARCH, 32'h7FFF_FFFF, '0);
        send_word(CMD_NEXT, '0, '0);
        send_word(CMD_NEXT, '0, '0);
        send_word(CMD_NEXT, '0, '0);
        send_word(CMD_NEXT, '0, '0);
        send_word(CMD_LAST, '0, '0);
        send_word(3'd5, '0, '0);
        send_word(3'd7, '0, '0);
        send_word(CMD_CLEAR, '0, '0);
        send_word(CMD_NEXT, '0, '0);
        drain();

        // Interior mode, tiny capacity, full and end-child cases.
        write_reg(CFG_INTERIOR, 32'd1);
        write_reg(CFG_CAPACITY, 32'd1);
        write_reg(CFG_END_CHILD, 32'hFFFF_FFFF);
        send_word(CMD_SEARCH, 32'h10, '0);
        send_word(CMD_INSERT, 32'h10, 32'hDEAD_BEEF);
        send_word(CMD_INSERT, 32'h20, 32'h1);
        send_word(CMD_SEARCH, 32'h10, '0);
        send_word(CMD_SEARCH, 32'h30, '0);
        drain();

        // Receiver held off while the sender keeps offering.
        write_reg(CFG_CAPACITY, 32'd64);
        calm = 0;
        fork
            begin
                hold_sink = 1;
                repeat (400) @(posedge aclk);
                hold_sink = 0;
            end
            random_phase(40);
        join
        drain();

        write_reg(CFG_CAPACITY, 32'd0);
        random_phase(60);
        drain();
        write_reg(CFG_INTERIOR, 32'd0);
        write_reg(CFG_CAPACITY, 32'd127);
        write_reg(CFG_END_CHILD, 32'h0);
        random_phase(350);
        drain();
        write_reg(CFG_CAPACITY, 32'd64);
        write_reg(CFG_INTERIOR, 32'd1);
        write_reg(CFG_END_CHILD, $urandom());
        calm = 1;
        random_phase(200);
        calm = 0;
        random_phase(300);
        drain();
        write_reg(CFG_CAPACITY, 32'd7);
        random_phase(150);
        drain();
        write_reg(CFG_CAPACITY, 32'd64);
        write_reg(CFG_INTERIOR, 32'd0);
        random_phase(300);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
